### hw/rtl/kccl_pkg.sv
// shared types and constants of the keypad code countdown lock
package kccl_pkg;

    localparam int CODE_KEYS = 4;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_ARM  = 2'd2;

    localparam logic [2:0] REG_PIN_CODE      = 3'd0;
    localparam logic [2:0] REG_PIN_LENGTH    = 3'd1;
    localparam logic [2:0] REG_ENTER_KEY     = 3'd2;
    localparam logic [2:0] REG_START_MINUTES = 3'd3;
    localparam logic [2:0] REG_START_SECONDS = 3'd4;
    localparam logic [2:0] REG_NORMAL_RELOAD = 3'd5;
    localparam logic [2:0] REG_ERROR_RELOAD  = 3'd6;

    localparam logic [6:0] MINUTES_MAX = 7'd99;
    localparam logic [5:0] SECONDS_MAX = 6'd59;

    localparam logic [31:0] PIN_CODE_RST      = 32'd151192065;
    localparam logic [2:0]  PIN_LENGTH_RST    = 3'd4;
    localparam logic [7:0]  ENTER_KEY_RST     = 8'd10;
    localparam logic [6:0]  START_MINUTES_RST = 7'd41;
    localparam logic [5:0]  START_SECONDS_RST = 6'd0;
    localparam logic [15:0] NORMAL_RELOAD_RST = 16'd24000;
    localparam logic [15:0] ERROR_RELOAD_RST  = 16'd2000;

    typedef struct packed {
        logic       push;
        logic       clear;
        logic [7:0] key;
    } kccl_hist_cmd_t;

    typedef struct packed {
        logic empty;
        logic match;
    } kccl_hist_stat_t;

endpackage

### hw/rtl/kccl_history.sv
// key history shift store, key count and code compare
module kccl_history #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kccl_pkg::kccl_hist_cmd_t cmd,
    input  logic [31:0]              pin_code,
    input  logic [2:0]               pin_length,
    output kccl_pkg::kccl_hist_stat_t stat
);
    import kccl_pkg::*;

    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic [7:0]    hist_reg [HISTORY_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full;
    logic          keys_ok;

    assign full = (count_reg == CW'(HISTORY_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.push && !full)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < HISTORY_DEPTH; i++)
    begin : g_entry
        localparam int SRC = (i == HISTORY_DEPTH - 1) ? i : i + 1;
        always_ff @(posedge clk)
        begin
            if (cmd.push)
            begin
                if (full)
                begin
                    hist_reg[i] <= (i == HISTORY_DEPTH - 1) ? cmd.key : hist_reg[SRC];
                end
                else if (count_reg == CW'(i))
                begin
                    hist_reg[i] <= cmd.key;
                end
            end
        end
    end

    always_comb
    begin
        keys_ok = 1'b1;
        for (int i = 0; i < CODE_KEYS; i++)
        begin
            if ((3'(i) < pin_length) && (hist_reg[i] != pin_code[8*i +: 8]))
            begin
                keys_ok = 1'b0;
            end
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.match = (pin_length != 3'd0) && (pin_length <= 3'(CODE_KEYS))
                        && (CW'(pin_length) == count_reg) && keys_ok;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HISTORY_DEPTH))
        else $error("key count beyond history depth");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> stat.empty)
        else $error("history not empty after clear");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push && !cmd.clear && !full |=> count_reg == $past(count_reg) + CW'(1))
        else $error("key count did not advance on push");
`endif

endmodule

### hw/rtl/keypad_code_countdown_lock_core.sv
// keypad code lock with minutes:seconds countdown, top level
//
// channel  direction  handshake             payload
// in       sink       in_valid / in_stall   kind, key_code
// out      source     out_valid / out_stall minutes_left .. fast_pace
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle while the result is not stalled
// the input register feeds one pass of update logic into the result register
// rst_n clears timer, flags, key count and the register file to defaults
// a stalled result holds; the input register keeps taking items until it is
// full behind a stalled result, then in_stall rises
module keypad_code_countdown_lock_core #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  key_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  minutes_left,
    output logic [5:0]  seconds_left,
    output logic        counting,
    output logic        defused,
    output logic        exploded,
    output logic        wrong_code,
    output logic        fast_pace,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import kccl_pkg::*;

    // register file
    logic [31:0] pin_code_reg;
    logic [2:0]  pin_length_reg;
    logic [7:0]  enter_key_reg;
    logic [6:0]  start_minutes_reg;
    logic [5:0]  start_seconds_reg;
    logic [15:0] normal_reload_reg;
    logic [15:0] error_reload_reg;

    // input stage
    logic        in_full_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  key_reg;
    logic        advance;

    // timer state
    logic [6:0]  minutes_reg, minutes_next;
    logic [5:0]  seconds_reg, seconds_next;
    logic [15:0] prescale_reg, prescale_next;
    logic        running_reg, running_next;
    logic        fast_reg, fast_next;
    logic        defused_reg, defused_next;
    logic        exploded_reg, exploded_next;
    logic        wrong_next;

    // result register
    logic        out_full_reg;
    logic [6:0]  minutes_out_reg;
    logic [5:0]  seconds_out_reg;
    logic        counting_out_reg;
    logic        defused_out_reg;
    logic        exploded_out_reg;
    logic        wrong_out_reg;
    logic        fast_out_reg;

    kccl_hist_cmd_t  hist_cmd;
    kccl_hist_stat_t hist_stat;

    logic [15:0] reload_raw;
    logic [15:0] reload_cur;
    logic [15:0] reload_arm;
    logic [6:0]  min_dec;
    logic [5:0]  sec_dec;
    logic        time_zero;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_code_reg      <= PIN_CODE_RST;
            pin_length_reg    <= PIN_LENGTH_RST;
            enter_key_reg     <= ENTER_KEY_RST;
            start_minutes_reg <= START_MINUTES_RST;
            start_seconds_reg <= START_SECONDS_RST;
            normal_reload_reg <= NORMAL_RELOAD_RST;
            error_reload_reg  <= ERROR_RELOAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PIN_CODE:      pin_code_reg      <= cfg_data;
                REG_PIN_LENGTH:    pin_length_reg    <= cfg_data[2:0];
                REG_ENTER_KEY:     enter_key_reg     <= cfg_data[7:0];
                REG_START_MINUTES: start_minutes_reg <= cfg_data[6:0];
                REG_START_SECONDS: start_seconds_reg <= cfg_data[5:0];
                REG_NORMAL_RELOAD: normal_reload_reg <= cfg_data[15:0];
                REG_ERROR_RELOAD:  error_reload_reg  <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // pipeline handshake
    assign advance  = in_full_reg && !(out_full_reg && out_stall);
    assign in_stall = in_full_reg && out_full_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg <= kind;
            key_reg  <= key_code;
        end
    end

    // update logic
    assign reload_raw = fast_reg ? error_reload_reg : normal_reload_reg;
    assign reload_cur = (reload_raw == 16'd0) ? 16'd1 : reload_raw;
    assign reload_arm = (normal_reload_reg == 16'd0) ? 16'd1 : normal_reload_reg;
    assign time_zero  = (minutes_reg == 7'd0) && (seconds_reg == 6'd0);
    assign sec_dec    = (seconds_reg == 6'd0) ? SECONDS_MAX : seconds_reg - 6'd1;
    assign min_dec    = (seconds_reg == 6'd0) ? minutes_reg - 7'd1 : minutes_reg;

    always_comb
    begin
        minutes_next  = minutes_reg;
        seconds_next  = seconds_reg;
        prescale_next = prescale_reg;
        running_next  = running_reg;
        fast_next     = fast_reg;
        defused_next  = defused_reg;
        exploded_next = exploded_reg;
        wrong_next    = 1'b0;
        hist_cmd      = '{push: 1'b0, clear: 1'b0, key: key_reg};
        if (advance)
        begin
            unique case (kind_reg)
                KIND_ARM:
                begin
                    minutes_next  = (start_minutes_reg > MINUTES_MAX) ? MINUTES_MAX
                                                                      : start_minutes_reg;
                    seconds_next  = (start_seconds_reg > SECONDS_MAX) ? SECONDS_MAX
                                                                      : start_seconds_reg;
                    hist_cmd.clear = 1'b1;
                    running_next  = 1'b1;
                    fast_next     = 1'b0;
                    defused_next  = 1'b0;
                    exploded_next = 1'b0;
                    prescale_next = reload_arm;
                end
                KIND_TICK:
                begin
                    if (running_reg)
                    begin
                        if (prescale_reg <= 16'd1)
                        begin
                            prescale_next = reload_cur;
                            if (time_zero)
                            begin
                                exploded_next = 1'b1;
                                running_next  = 1'b0;
                            end
                            else
                            begin
                                minutes_next = min_dec;
                                seconds_next = sec_dec;
                                if ((min_dec == 7'd0) && (sec_dec == 6'd0))
                                begin
                                    exploded_next = 1'b1;
                                    running_next  = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            prescale_next = prescale_reg - 16'd1;
                        end
                    end
                end
                KIND_KEY:
                begin
                    if (running_reg)
                    begin
                        if (key_reg == enter_key_reg)
                        begin
                            if (!hist_stat.empty)
                            begin
                                if (hist_stat.match)
                                begin
                                    defused_next = 1'b1;
                                    running_next = 1'b0;
                                end
                                else
                                begin
                                    wrong_next = 1'b1;
                                    fast_next  = 1'b1;
                                end
                            end
                            hist_cmd.clear = 1'b1;
                        end
                        else
                        begin
                            hist_cmd.push = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minutes_reg  <= '0;
            seconds_reg  <= '0;
            prescale_reg <= '0;
            running_reg  <= 1'b0;
            fast_reg     <= 1'b0;
            defused_reg  <= 1'b0;
            exploded_reg <= 1'b0;
        end
        else
        begin
            minutes_reg  <= minutes_next;
            seconds_reg  <= seconds_next;
            prescale_reg <= prescale_next;
            running_reg  <= running_next;
            fast_reg     <= fast_next;
            defused_reg  <= defused_next;
            exploded_reg <= exploded_next;
        end
    end

    kccl_history #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_history (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (hist_cmd),
        .pin_code   (pin_code_reg),
        .pin_length (pin_length_reg),
        .stat       (hist_stat)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_full_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            minutes_out_reg  <= minutes_next;
            seconds_out_reg  <= seconds_next;
            counting_out_reg <= running_next;
            defused_out_reg  <= defused_next;
            exploded_out_reg <= exploded_next;
            wrong_out_reg    <= wrong_next;
            fast_out_reg     <= fast_next;
        end
    end

    assign out_valid    = out_full_reg;
    assign minutes_left = minutes_out_reg;
    assign seconds_left = seconds_out_reg;
    assign counting     = counting_out_reg;
    assign defused      = defused_out_reg;
    assign exploded     = exploded_out_reg;
    assign wrong_code   = wrong_out_reg;
    assign fast_pace    = fast_out_reg;

`ifndef SYNTH
    a_end_states_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(defused_reg && exploded_reg))
        else $error("defused and exploded both set");
    a_running_not_ended: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> !defused_reg && !exploded_reg)
        else $error("count running after an end state");
    a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
        seconds_reg <= SECONDS_MAX)
        else $error("seconds count out of range");
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_full_reg && $stable(kind_reg) && $stable(key_reg))
        else $error("input stage lost an item under stall");
`endif

endmodule
